### rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types and constants of the signed integer to decimal text core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 8;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_IDX_W    = 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  // one word in flight through the conversion pipeline
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] bin;
    bcd_t               bcd;
  } dd_word_t;

endpackage

`default_nettype wire

### rtl/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// converts a signed 32-bit integer into its decimal ascii text, one
// character word per cycle, most significant first
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  command   start_i, value_i               in         taken when start_i && !busy_o
//  busy      busy_o                         out        high while no command can enter
//  result    valid_o, character_o, last_o   out        one cycle strobe, no back pressure
//
//  a command goes through an input register, eight shift-add-3 stages, the
//  sequencer state and its output register before its first character word appears
//  each number gives 1 to 11 character words, and the sequencer takes the next
//  number in the cycle it forms the last word; the pipeline keeps converting
//  meanwhile and holds only while its final stage has a word not yet taken
//  reset clears all valid bits and the sequencer; busy_o is low after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [sitda_pkg::VALUE_W-1:0] value_i,
  output logic                                     valid_o,
  output logic [sitda_pkg::CHAR_W-1:0]             character_o,
  output logic                                     last_o
);

  localparam int Stages = sitda_pkg::NUM_STAGES;

  // valid bit and word per pipeline boundary; index 0 is the input register
  logic                stage_valid [Stages+1];
  sitda_pkg::dd_word_t stage_word  [Stages+1];

  logic                adv;
  logic                accept;
  logic                emit_free;
  logic                take;
  logic                in_valid_q;
  sitda_pkg::dd_word_t in_word_d, in_word_q;
  logic [sitda_pkg::VALUE_W-1:0] raw;

  // whole pipeline moves together; it holds only when the final stage
  // has a word the sequencer cannot take yet
  assign take   = stage_valid[Stages] && emit_free;
  assign adv    = !stage_valid[Stages] || emit_free;
  assign busy_o = !adv;
  assign accept = start_i && !busy_o;

  // magnitude as unsigned, so the most negative value gives 2147483648
  always_comb begin
    raw           = unsigned'(value_i);
    in_word_d.neg = raw[sitda_pkg::VALUE_W-1];
    in_word_d.bin = raw[sitda_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
    in_word_d.bcd = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_word_q <= in_word_d;
    end
  end

  assign stage_valid[0] = in_valid_q;
  assign stage_word[0]  = in_word_q;

  // binary to bcd, four bits per stage
  for (genvar g = 0; g < Stages; g++) begin : g_dabble
    sitda_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stage_valid[g]),
      .word_i  (stage_word[g]),
      .valid_o (stage_valid[g+1]),
      .word_o  (stage_word[g+1])
    );
  end

  // sign and digit sequencer with registered output
  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (stage_word[Stages]),
    .free_o      (emit_free),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

### rtl/sitda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// one pipeline stage of shift-add-3 conversion, four binary bits per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_dabble_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                valid_i,
  input  wire sitda_pkg::dd_word_t word_i,
  output logic                     valid_o,
  output sitda_pkg::dd_word_t      word_o
);

  logic                valid_q;
  sitda_pkg::dd_word_t word_d, word_q;

  always_comb begin
    logic [sitda_pkg::NUM_DIGITS*4-1:0] flat;
    logic [sitda_pkg::VALUE_W-1:0]      bin;
    sitda_pkg::bcd_t                    bcd;
    bcd = word_i.bcd;
    bin = word_i.bin;
    for (int s = 0; s < sitda_pkg::BITS_PER_STAGE; s++) begin
      // correct every digit that would pass nine after doubling
      for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
        if (bcd[d] >= 4'd5) begin
          bcd[d] = bcd[d] + 4'd3;
        end
      end
      flat = bcd;
      flat = {flat[sitda_pkg::NUM_DIGITS*4-2:0], bin[sitda_pkg::VALUE_W-1]};
      bin  = {bin[sitda_pkg::VALUE_W-2:0], 1'b0};
      bcd  = flat;
    end
    word_d.neg = word_i.neg;
    word_d.bin = bin;
    word_d.bcd = bcd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

### rtl/sitda_emit.sv
// ----------------------------------------------------------------------------
// sitda_emit
// character sequencer: sign, then digits from the leading nonzero one down
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitda_emit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire sitda_pkg::dd_word_t           word_i,
  output logic                               free_o,
  output logic                               valid_o,
  output logic [sitda_pkg::CHAR_W-1:0]       character_o,
  output logic                               last_o
);

  logic                                active_d, active_q;
  logic                                sign_d, sign_q;
  logic [sitda_pkg::DIGIT_IDX_W-1:0]   idx_d, idx_q;
  logic [sitda_pkg::DIGIT_IDX_W-1:0]   lead;
  sitda_pkg::bcd_t                     bcd_d, bcd_q;
  logic                                valid_d, valid_q;
  logic [sitda_pkg::CHAR_W-1:0]        char_d, char_q;
  logic                                last_d, last_q;

  // highest nonzero digit, zero gives the units place
  always_comb begin
    lead = '0;
    for (int d = 1; d < sitda_pkg::NUM_DIGITS; d++) begin
      if (word_i.bcd[d] != 4'd0) begin
        lead = sitda_pkg::DIGIT_IDX_W'(d);
      end
    end
  end

  assign free_o = !active_q || (!sign_q && (idx_q == '0));

  always_comb begin
    active_d = active_q;
    sign_d   = sign_q;
    idx_d    = idx_q;
    bcd_d    = bcd_q;
    valid_d  = 1'b0;
    char_d   = char_q;
    last_d   = 1'b0;
    if (active_q) begin
      valid_d = 1'b1;
      if (sign_q) begin
        char_d = sitda_pkg::ASCII_MINUS;
        sign_d = 1'b0;
      end else begin
        char_d = sitda_pkg::ASCII_ZERO + {4'b0000, bcd_q[idx_q]};
        if (idx_q == '0) begin
          last_d   = 1'b1;
          active_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end
    if (take_i) begin
      active_d = 1'b1;
      sign_d   = word_i.neg;
      idx_d    = lead;
      bcd_d    = word_i.bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sign_q   <= 1'b0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      sign_q   <= sign_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
